>>> sv/ecd_pkg.sv
// Event channel dispatcher package: sizes, command codes, FSM states and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package ecd_pkg;

  localparam int CHANNELS  = 1024;
  localparam int WORD_BITS = 64;
  localparam int WORDS     = CHANNELS / WORD_BITS;
  localparam int WORD_W    = $clog2(WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PORT_W    = 10;
  localparam int CMD_W     = 3;
  localparam int IN_W      = 16;  // cmd + port + flag, padded to bytes
  localparam int OUT_W     = 16;  // event_port + found + scan_left + irq, padded

  typedef enum logic [CMD_W-1:0] {
    CMD_MASK    = 3'd0,
    CMD_UNMASK  = 3'd1,
    CMD_RAISE   = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_START   = 3'd4,
    CMD_NEXT    = 3'd5,
    CMD_UPMASK  = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic exec;     // run a single-step command
    logic scan;     // one word of a next-event scan
    logic load_out; // move the result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_next;
    logic scan_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/ecd_ctrl.sv
// Event channel dispatcher controller: sequences capture, execute, scan and
// result hand-off. Depends on ecd_pkg.
`default_nettype none

module ecd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_free_i,
  input  wire ecd_pkg::dp_stat_t stat_i,
  output ecd_pkg::dp_cmd_t      cmd_o
);

  ecd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ecd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ecd_pkg::ST_EXEC;
      end
      ecd_pkg::ST_EXEC: begin
        state_d = stat_i.is_next ? ecd_pkg::ST_SCAN : ecd_pkg::ST_DONE;
      end
      ecd_pkg::ST_SCAN: begin
        if (stat_i.scan_done) state_d = ecd_pkg::ST_DONE;
      end
      ecd_pkg::ST_DONE: begin
        if (out_free_i) state_d = ecd_pkg::ST_IDLE;
      end
      default: state_d = ecd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ecd_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ecd_pkg::ST_EXEC: cmd_o.exec     = 1'b1;
      ecd_pkg::ST_SCAN: cmd_o.scan     = 1'b1;
      ecd_pkg::ST_DONE: cmd_o.load_out = out_free_i;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ecd_datapath.sv
// Event channel dispatcher datapath: pending/mask word arrays, selector,
// scan snapshot, upcall flags and the result registers. Depends on ecd_pkg.
`default_nettype none

module ecd_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ecd_pkg::IN_W-1:0]  in_data_i,
  input  wire ecd_pkg::dp_cmd_t          cmd_i,
  output ecd_pkg::dp_stat_t              stat_o,
  output logic [ecd_pkg::PORT_W-1:0]     event_port_o,
  output logic                           event_found_o,
  output logic                           scan_left_o,
  output logic                           irq_request_o
);

  localparam logic [ecd_pkg::PORT_W:0] ChanLimit = (ecd_pkg::PORT_W+1)'(ecd_pkg::CHANNELS);

  // captured beat
  ecd_pkg::cmd_e                  cmd_q;
  logic [ecd_pkg::PORT_W-1:0]     port_q;
  logic                           flag_q;

  logic [ecd_pkg::WORD_BITS-1:0]  pend_q [ecd_pkg::WORDS];
  logic [ecd_pkg::WORD_BITS-1:0]  mask_q [ecd_pkg::WORDS];
  logic [ecd_pkg::WORDS-1:0]      wsel_q, wsel_d;
  logic [ecd_pkg::WORDS-1:0]      snap_q, snap_d;
  logic                           up_pend_q, up_pend_d;
  logic                           up_mask_q, up_mask_d;
  logic [ecd_pkg::PORT_W-1:0]     ev_port_q, ev_port_d;
  logic                           ev_found_q, ev_found_d;

  logic [ecd_pkg::WORD_W-1:0]     port_w, scan_w, sel_w;
  logic [ecd_pkg::BIT_W-1:0]      port_b, first_b;
  logic [ecd_pkg::WORD_BITS-1:0]  bit_m, rd_p, rd_m, act, p_new, m_new;
  logic                           port_ok, wr_p, wr_m, act_any, rem_zero, snap_any;

  assign port_w  = port_q[ecd_pkg::BIT_W +: ecd_pkg::WORD_W];
  assign port_b  = port_q[ecd_pkg::BIT_W-1:0];
  assign port_ok = {1'b0, port_q} < ChanLimit;
  assign bit_m   = ecd_pkg::WORD_BITS'(1) << port_b;
  assign snap_any = |snap_q;

  // lowest word still in the snapshot
  always_comb begin
    scan_w = '0;
    for (int i = ecd_pkg::WORDS - 1; i >= 0; i--) begin
      if (snap_q[i]) scan_w = ecd_pkg::WORD_W'(i);
    end
  end

  assign sel_w = cmd_i.scan ? scan_w : port_w;
  assign rd_p  = pend_q[sel_w];
  assign rd_m  = mask_q[sel_w];
  assign act   = rd_p & ~rd_m;
  assign act_any = |act;
  assign rem_zero = (act & (act - ecd_pkg::WORD_BITS'(1))) == '0;

  always_comb begin
    first_b = '0;
    for (int k = ecd_pkg::WORD_BITS - 1; k >= 0; k--) begin
      if (act[k]) first_b = ecd_pkg::BIT_W'(k);
    end
  end

  assign stat_o.is_next   = (cmd_q == ecd_pkg::CMD_NEXT);
  assign stat_o.scan_done = !snap_any || act_any;

  always_comb begin
    wsel_d     = wsel_q;
    snap_d     = snap_q;
    up_pend_d  = up_pend_q;
    up_mask_d  = up_mask_q;
    ev_port_d  = ev_port_q;
    ev_found_d = ev_found_q;
    wr_p       = 1'b0;
    wr_m       = 1'b0;
    p_new      = rd_p;
    m_new      = rd_m;
    if (cmd_i.exec) begin
      ev_port_d  = '0;
      ev_found_d = 1'b0;
      case (cmd_q)
        ecd_pkg::CMD_MASK: begin
          wr_m  = port_ok;
          m_new = rd_m | bit_m;
        end
        ecd_pkg::CMD_UNMASK: begin
          wr_m  = port_ok;
          m_new = rd_m & ~bit_m;
          if (port_ok && (rd_p & bit_m) != '0 && !wsel_q[port_w]) begin
            wsel_d[port_w] = 1'b1;
            up_pend_d      = 1'b1;
          end
        end
        ecd_pkg::CMD_RAISE: begin
          wr_p  = port_ok;
          p_new = rd_p | bit_m;
          if (port_ok && (rd_m & bit_m) == '0 && !wsel_q[port_w]) begin
            wsel_d[port_w] = 1'b1;
            up_pend_d      = 1'b1;
          end
        end
        ecd_pkg::CMD_CLEAR: begin
          wr_p  = port_ok;
          p_new = rd_p & ~bit_m;
        end
        ecd_pkg::CMD_START: begin
          up_pend_d = 1'b0;
          snap_d    = snap_q | wsel_q;
          wsel_d    = '0;
        end
        ecd_pkg::CMD_UPMASK: up_mask_d = flag_q;
        default: ;
      endcase
    end else if (cmd_i.scan && snap_any) begin
      if (!act_any) begin
        snap_d[scan_w] = 1'b0;
      end else begin
        wr_p       = 1'b1;
        p_new      = rd_p & ~(ecd_pkg::WORD_BITS'(1) << first_b);
        ev_port_d  = {scan_w, first_b};
        ev_found_d = 1'b1;
        if (rem_zero) snap_d[scan_w] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= ecd_pkg::cmd_e'(in_data_i[ecd_pkg::CMD_W-1:0]);
      port_q <= in_data_i[ecd_pkg::CMD_W +: ecd_pkg::PORT_W];
      flag_q <= in_data_i[ecd_pkg::CMD_W + ecd_pkg::PORT_W];
    end
    ev_port_q  <= ev_port_d;
    ev_found_q <= ev_found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ecd_pkg::WORDS; i++) begin
        pend_q[i] <= '0;
        mask_q[i] <= '1;
      end
      wsel_q    <= '0;
      snap_q    <= '0;
      up_pend_q <= 1'b0;
      up_mask_q <= 1'b0;
    end else begin
      if (wr_p) pend_q[sel_w] <= p_new;
      if (wr_m) mask_q[sel_w] <= m_new;
      wsel_q    <= wsel_d;
      snap_q    <= snap_d;
      up_pend_q <= up_pend_d;
      up_mask_q <= up_mask_d;
    end
  end

  assign event_port_o  = ev_port_q;
  assign event_found_o = ev_found_q;
  assign scan_left_o   = snap_any;
  assign irq_request_o = up_pend_q & ~up_mask_q;

endmodule

`default_nettype wire

>>> sv/event_channel_dispatcher.sv
// Event channel dispatcher top level: stream ports, output register, and the
// controller/datapath pair. Depends on ecd_pkg, ecd_ctrl, ecd_datapath.
//
// One command beat in, one result beat out. Commands are handled one at a
// time: a single-step command (mask, unmask, raise, clear, start, set upcall
// mask, unused code) is captured, executed and then loaded into the output
// register. A next-event command is captured, then scans the selected words,
// dropping those found empty (at most 16) until a port is dispatched or none
// is left, and is then loaded; the scan examines one pending/mask word per cycle.
// The next command is accepted in the cycle after a result is loaded.
// The output register holds one result, so the next command is accepted while
// that result waits to be taken; the result after it is held back until the
// register is free.
`default_nettype none

module event_channel_dispatcher (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] cmd, [12:3] port, [13] flag, [15:14] zero
  input  wire logic [ecd_pkg::IN_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [9:0] event_port, [10] event_found, [11] scan_left, [12] irq_request,
  // [15:13] zero
  output logic [ecd_pkg::OUT_W-1:0]     m_axis_tdata
);

  localparam int ResW = ecd_pkg::PORT_W + 3;

  ecd_pkg::dp_cmd_t  dp_cmd;
  ecd_pkg::dp_stat_t dp_stat;

  logic [ecd_pkg::PORT_W-1:0] event_port;
  logic                       event_found, scan_left, irq_request;
  logic                       out_valid_q;
  logic [ResW-1:0]            out_data_q;
  logic                       out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  ecd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ecd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_data_i     (s_axis_tdata),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .event_port_o  (event_port),
    .event_found_o (event_found),
    .scan_left_o   (scan_left),
    .irq_request_o (irq_request)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd.load_out) begin
      out_data_q <= {irq_request, scan_left, event_found, event_port};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(ecd_pkg::OUT_W - ResW)'(0), out_data_q};

endmodule

`default_nettype wire

>>> verif/tb_event_channel_dispatcher.sv
// Self-checking testbench for event_channel_dispatcher: drives command beats,
// predicts every result beat with its own copy of the pending/mask/selector state.
// Depends on ecd_pkg and the event_channel_dispatcher RTL.
module tb_event_channel_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  import ecd_pkg::*;

  typedef struct {
    logic [PORT_W-1:0] port;
    logic              found;
    logic              left;
    logic              irq;
  } dispatch_result_t;

  // Tracks the channel state and holds the results still owed by the block.
  class dispatch_scoreboard;
    logic [WORD_BITS-1:0] pend_bits [WORDS];
    logic [WORD_BITS-1:0] mask_bits [WORDS];
    logic [WORDS-1:0]     word_sel;
    logic [WORDS-1:0]     scan_snap;
    logic                 upcall_pend;
    logic                 upcall_msk;
    dispatch_result_t     owed_q [$];
    int                   errors;
    int                   checked;
    int                   dispatched;

    function new();
      for (int i = 0; i < WORDS; i++) begin
        pend_bits[i] = '0;
        mask_bits[i] = '1;
      end
      word_sel    = '0;
      scan_snap   = '0;
      upcall_pend = 1'b0;
      upcall_msk  = 1'b0;
      errors      = 0;
      checked     = 0;
      dispatched  = 0;
    endfunction

    function int pending_results();
      return owed_q.size();
    endfunction

    function void flag_word(int w);
      if (!word_sel[w]) begin
        word_sel[w] = 1'b1;
        upcall_pend = 1'b1;
      end
    endfunction

    // Applies one accepted command beat and queues the result it must produce.
    function void note_command(cmd_e c, logic [PORT_W-1:0] p, logic f);
      dispatch_result_t     r;
      logic [WORD_BITS-1:0] act;
      int                   w;
      int                   b;
      int                   low;
      logic                 hit;
      w   = p[PORT_W-1:BIT_W];
      b   = p[BIT_W-1:0];
      r.port  = '0;
      r.found = 1'b0;
      hit = 1'b0;
      case (c)
        CMD_MASK: mask_bits[w][b] = 1'b1;
        CMD_UNMASK: begin
          mask_bits[w][b] = 1'b0;
          if (pend_bits[w][b]) flag_word(w);
        end
        CMD_RAISE: begin
          pend_bits[w][b] = 1'b1;
          if (!mask_bits[w][b]) flag_word(w);
        end
        CMD_CLEAR: pend_bits[w][b] = 1'b0;
        CMD_START: begin
          upcall_pend = 1'b0;
          scan_snap   = scan_snap | word_sel;
          word_sel    = '0;
        end
        CMD_NEXT: begin
          // empty selected words are dropped on the way to the first live one
          for (int i = 0; i < WORDS; i++) begin
            if (!hit && scan_snap[i]) begin
              act = pend_bits[i] & ~mask_bits[i];
              if (act == '0) begin
                scan_snap[i] = 1'b0;
              end else begin
                low = 0;
                for (int k = WORD_BITS - 1; k >= 0; k--)
                  if (act[k]) low = k;
                pend_bits[i][low] = 1'b0;
                r.port  = PORT_W'(i * WORD_BITS + low);
                r.found = 1'b1;
                hit     = 1'b1;
                dispatched++;
                if ((pend_bits[i] & ~mask_bits[i]) == '0) scan_snap[i] = 1'b0;
              end
            end
          end
        end
        CMD_UPMASK: upcall_msk = f;
        default: ;
      endcase
      r.left = |scan_snap;
      r.irq  = upcall_pend & ~upcall_msk;
      owed_q.push_back(r);
    endfunction

    function void report(string field, logic [PORT_W-1:0] want, logic [PORT_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      dispatch_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h, expected none", $time, d);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (d[9:0] !== want.port) report("event_port", want.port, d[9:0]);
      if (d[10] !== want.found) report("event_found", want.found, d[10]);
      if (d[11] !== want.left) report("scan_left", want.left, d[11]);
      if (d[12] !== want.irq) report("irq_request", want.irq, d[12]);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // [2:0] cmd, [12:3] port, [13] flag
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;   // [9:0] port, [10] found, [11] left, [12] irq

  int send_idle_pct;
  int recv_idle_pct;
  int sent_count;

  dispatch_scoreboard sb = new();

  event_channel_dispatcher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check the beat taken at this edge, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_cmd(cmd_e c, logic [PORT_W-1:0] p, logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, f, p, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c, p, f);
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results() != 0) @(posedge clk_i);
  endtask

  task automatic send_noise();
    send_cmd(cmd_e'($urandom_range(0, 7)), PORT_W'($urandom_range(0, CHANNELS - 1)),
             1'($urandom_range(0, 1)));
  endtask

  // Arms a handful of ports in a few words, opens a scan and drains it.
  task automatic run_episode();
    logic [PORT_W-1:0] ports [8];
    logic [WORD_W-1:0] words [3];
    int                n;
    int                r;
    int                nexts;
    n = $urandom_range(1, 8);
    for (int i = 0; i < 3; i++) words[i] = WORD_W'($urandom_range(0, WORDS - 1));
    for (int i = 0; i < n; i++)
      ports[i] = {words[$urandom_range(0, 2)], BIT_W'($urandom_range(0, WORD_BITS - 1))};
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r <= 5) begin
        send_cmd(CMD_RAISE, ports[i], 1'b0);
        send_cmd(CMD_UNMASK, ports[i], 1'b0);
      end else if (r <= 7) begin
        send_cmd(CMD_UNMASK, ports[i], 1'b0);
        send_cmd(CMD_RAISE, ports[i], 1'b0);
      end else if (r == 8) begin
        send_cmd(CMD_RAISE, ports[i], 1'b1);
      end else begin
        send_cmd(CMD_RAISE, ports[i], 1'b0);
        send_cmd(CMD_MASK, ports[i], 1'b0);
      end
    end
    if ($urandom_range(7) == 0) send_cmd(CMD_CLEAR, ports[$urandom_range(0, n - 1)], 1'b0);
    if ($urandom_range(5) == 0) send_cmd(CMD_UPMASK, '0, 1'($urandom_range(0, 1)));
    if ($urandom_range(9) == 0) send_noise();
    send_cmd(CMD_START, PORT_W'($urandom_range(0, CHANNELS - 1)), 1'b0);
    nexts = n + $urandom_range(0, 2);
    for (int j = 0; j < nexts; j++) begin
      r = $urandom_range(19);
      if (r == 0) begin
        send_cmd(CMD_START, '0, 1'b0);
      end else if (r == 1) begin
        send_cmd(CMD_RAISE, ports[$urandom_range(0, n - 1)], 1'b0);
      end else if (r == 2) begin
        send_cmd(CMD_UNMASK, {words[$urandom_range(0, 2)],
                              BIT_W'($urandom_range(0, WORD_BITS - 1))}, 1'b0);
      end
      send_cmd(CMD_NEXT, PORT_W'($urandom_range(0, CHANNELS - 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int snd_pct, int rcv_pct, int items);
    int goal;
    bit held;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    goal = sent_count + items;
    held = 1'b0;
    while (sent_count < goal) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 5)) send_noise();
      end else begin
        run_episode();
      end
      // hold the sender once mid-phase until the block has caught up
      if (!held && sent_count >= goal - items / 2) begin
        wait_drained();
        held = 1'b1;
      end
    end
    wait_drained();
  endtask

  task automatic run_directed();
    send_cmd(CMD_NEXT, '0, 1'b0);           // nothing to dispatch
    send_cmd(CMD_RAISE, 10'd0, 1'b0);       // masked: no signal
    send_cmd(CMD_UNMASK, 10'd0, 1'b0);      // pending: selects word, raises upcall
    send_cmd(CMD_UNMASK, 10'd1023, 1'b1);
    send_cmd(CMD_RAISE, 10'd1023, 1'b0);
    send_cmd(CMD_UPMASK, 10'd1023, 1'b1);
    send_cmd(CMD_UPMASK, '0, 1'b0);
    send_cmd(CMD_START, '0, 1'b0);
    send_cmd(CMD_UNMASK, 10'd63, 1'b0);
    send_cmd(CMD_RAISE, 10'd63, 1'b0);
    send_cmd(CMD_START, 10'd512, 1'b1);     // start while a scan is open
    send_cmd(CMD_NEXT, '0, 1'b0);
    send_cmd(CMD_NEXT, '1, 1'b1);
    send_cmd(CMD_NEXT, '0, 1'b0);
    send_cmd(CMD_NEXT, '0, 1'b0);
    send_cmd(CMD_NOP, '1, 1'b1);            // unused code
    send_cmd(CMD_RAISE, 10'd64, 1'b0);
    send_cmd(CMD_UNMASK, 10'd64, 1'b0);
    send_cmd(CMD_START, '0, 1'b0);
    send_cmd(CMD_CLEAR, 10'd64, 1'b0);      // selected word left empty
    send_cmd(CMD_NEXT, '0, 1'b0);
    send_cmd(CMD_MASK, 10'd1023, 1'b0);
    send_cmd(CMD_CLEAR, 10'd1023, 1'b0);
    send_cmd(CMD_MASK, 10'd682, 1'b0);
    send_cmd(CMD_CLEAR, 10'd341, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_count    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_phase(22, 88, 580);
    run_phase(88, 22, 580);
    run_phase(0, 0, 580);
    s_axis_tvalid <= 1'b0;
    repeat (25) @(posedge clk_i);
    $display("Ran %0d command beats through three flow-control phases;", sent_count);
    $display("checked %0d result beats, %0d of them dispatching a port.",
             sb.checked, sb.dispatched);
    if (sb.errors == 0 && sb.pending_results() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out waiting for the block");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
